[rtl/core/ddam_pkg.sv]
// Package for the decimal add and multiply engine: payload structs, request
// codes, register indexes and the controller-to-datapath command struct.
// Used by every module of the block but ddam_ram; depends on nothing.
package ddam_pkg;

  localparam int MAX_DIGITS_DEF = 128;

  localparam logic [7:0] LEN_RESET = 8'd1;
  localparam logic [3:0] DIGIT_MAX = 4'd9;
  localparam logic [7:0] TOP_SAT   = 8'd255;

  // Request codes carried in req_type.
  localparam logic [2:0] REQ_LOAD_A  = 3'd0;
  localparam logic [2:0] REQ_LOAD_B  = 3'd1;
  localparam logic [2:0] REQ_COMPUTE = 3'd2;
  localparam logic [2:0] REQ_READ_S  = 3'd3;
  localparam logic [2:0] REQ_READ_P  = 3'd4;

  // Register index taken from address bit 2.
  localparam logic REG_LEN_A = 1'b0;
  localparam logic REG_LEN_B = 1'b1;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] position;
    logic [3:0] digit_in;
  } ddam_in_t;

  typedef struct packed {
    logic [3:0] digit_out;
    logic [7:0] top_index;
  } ddam_out_t;

  typedef struct packed {
    logic clr;        // clearing pass: zero all stores at column col
    logic acc_clr;    // start of a compute: zero accumulator and top indexes
    logic rd;         // read operand digits at a_addr and b_addr
    logic a_ok;       // operand A digit counts (inside its length)
    logic b_ok;       // operand B digit counts
    logic mul;        // accumulate the product of the digits, else their sum
    logic norm;       // split accumulator by ten and store the digit at col
    logic norm_prod;  // the stored digit goes to the product, else the sum
  } ddam_cmd_t;

endpackage

[rtl/core/ddam_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for every digit store of the engine; no package dependencies.
module ddam_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/ddam_ctrl.sv]
// Sequencer of the decimal engine: clearing pass after reset, the column
// loop of the sum and the column and digit loops of the schoolbook product.
// Depends on ddam_pkg for request codes and the command struct.
module ddam_ctrl #(
  parameter int MAX_DIGITS = ddam_pkg::MAX_DIGITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [2:0]                      req_type,
  input  logic [7:0]                      len_a,
  input  logic [7:0]                      len_b,
  output logic                            busy,
  output ddam_pkg::ddam_cmd_t             cmd,
  output logic [$clog2(2*MAX_DIGITS)-1:0] col,
  output logic [$clog2(MAX_DIGITS)-1:0]   a_addr,
  output logic [$clog2(MAX_DIGITS)-1:0]   b_addr
);

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int PW = $clog2(2*MAX_DIGITS);
  localparam int EW = ((PW > 8) ? PW : 8) + 1;

  localparam logic [PW-1:0] COL_LAST = PW'(2*MAX_DIGITS - 1);
  localparam logic [PW-1:0] SUM_LAST = PW'(MAX_DIGITS);
  localparam logic [EW-1:0] MAX_E    = EW'(MAX_DIGITS);

  localparam logic [3:0] ST_CLR     = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_SUM_RD  = 4'd2;
  localparam logic [3:0] ST_SUM_DRN = 4'd3;
  localparam logic [3:0] ST_SUM_NRM = 4'd4;
  localparam logic [3:0] ST_PRD_COL = 4'd5;
  localparam logic [3:0] ST_PRD_RUN = 4'd6;
  localparam logic [3:0] ST_PRD_DRN = 4'd7;
  localparam logic [3:0] ST_PRD_NRM = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [PW-1:0] k_r, k_nxt;
  logic [PW-1:0] i_r, i_nxt;

  logic [EW-1:0] k_e, i_e, la_e, lb_e, lo_e, hi_e;
  logic          col_empty;
  logic [PW-1:0] kmi;

  // Effective lengths are capped at the store depth.
  assign k_e  = EW'(k_r);
  assign i_e  = EW'(i_r);
  assign la_e = (EW'(len_a) > MAX_E) ? MAX_E : EW'(len_a);
  assign lb_e = (EW'(len_b) > MAX_E) ? MAX_E : EW'(len_b);

  // Column k of the product takes A digit i and B digit k-i with both
  // inside their lengths: i runs from lo to hi.
  assign lo_e      = (k_e >= lb_e) ? (k_e - lb_e + EW'(1)) : '0;
  assign hi_e      = (k_e < la_e) ? k_e : (la_e - EW'(1));
  assign col_empty = (la_e == '0) || (lb_e == '0) || (lo_e > hi_e);

  assign kmi    = k_r - i_r;
  assign col    = k_r;
  assign a_addr = (state_r == ST_SUM_RD) ? k_r[AW-1:0] : i_r[AW-1:0];
  assign b_addr = (state_r == ST_SUM_RD) ? k_r[AW-1:0] : kmi[AW-1:0];
  assign busy   = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLR: begin
        cmd.clr = 1'b1;
        if (k_r == COL_LAST) begin
          k_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          k_nxt = k_r + PW'(1);
        end
      end
      ST_IDLE: begin
        if (start && (req_type == ddam_pkg::REQ_COMPUTE)) begin
          cmd.acc_clr = 1'b1;
          k_nxt       = '0;
          state_nxt   = ST_SUM_RD;
        end
      end
      ST_SUM_RD: begin
        cmd.rd    = 1'b1;
        cmd.a_ok  = (k_e < la_e);
        cmd.b_ok  = (k_e < lb_e);
        state_nxt = ST_SUM_DRN;
      end
      ST_SUM_DRN: begin
        state_nxt = ST_SUM_NRM;
      end
      ST_SUM_NRM: begin
        cmd.norm = 1'b1;
        if (k_r == SUM_LAST) begin
          k_nxt     = '0;
          state_nxt = ST_PRD_COL;
        end else begin
          k_nxt     = k_r + PW'(1);
          state_nxt = ST_SUM_RD;
        end
      end
      ST_PRD_COL: begin
        if (col_empty) begin
          state_nxt = ST_PRD_NRM;
        end else begin
          i_nxt     = lo_e[PW-1:0];
          state_nxt = ST_PRD_RUN;
        end
      end
      ST_PRD_RUN: begin
        cmd.rd   = 1'b1;
        cmd.a_ok = 1'b1;
        cmd.b_ok = 1'b1;
        cmd.mul  = 1'b1;
        if (i_e == hi_e) begin
          state_nxt = ST_PRD_DRN;
        end else begin
          i_nxt = i_r + PW'(1);
        end
      end
      ST_PRD_DRN: begin
        state_nxt = ST_PRD_NRM;
      end
      ST_PRD_NRM: begin
        cmd.norm      = 1'b1;
        cmd.norm_prod = 1'b1;
        if (k_r == COL_LAST) begin
          k_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          k_nxt     = k_r + PW'(1);
          state_nxt = ST_PRD_COL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      k_r     <= '0;
      i_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      i_r     <= i_nxt;
    end
  end

  a_compute_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (req_type == ddam_pkg::REQ_COMPUTE)) |=> busy)
    else $error("compute transfer did not start the sequencer");

  a_digit_index_in_column: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PRD_RUN) |-> ((i_r <= k_r) && (kmi < PW'(MAX_DIGITS))))
    else $error("product digit index outside the column");

  a_no_read_while_norm: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rd && cmd.norm))
    else $error("operand read and column split in the same cycle");

endmodule

[rtl/core/ddam_dpath.sv]
// Datapath of the decimal engine: operand, sum and product digit stores,
// the column accumulator with its split by ten, top indexes and read results.
// Depends on ddam_pkg and instantiates ddam_ram.
module ddam_dpath #(
  parameter int MAX_DIGITS = ddam_pkg::MAX_DIGITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  ddam_pkg::ddam_in_t              in_item,
  input  ddam_pkg::ddam_cmd_t             cmd,
  input  logic [$clog2(2*MAX_DIGITS)-1:0] col,
  input  logic [$clog2(MAX_DIGITS)-1:0]   a_addr,
  input  logic [$clog2(MAX_DIGITS)-1:0]   b_addr,
  output logic                            out_valid,
  output ddam_pkg::ddam_out_t             out_item
);

  localparam int AW    = $clog2(MAX_DIGITS);
  localparam int SDEP  = MAX_DIGITS + 1;
  localparam int SW    = $clog2(SDEP);
  localparam int PDEP  = 2 * MAX_DIGITS;
  localparam int PW    = $clog2(PDEP);
  localparam int EW    = ((PW > 8) ? PW : 8) + 1;
  localparam int ACC_W = $clog2(90 * MAX_DIGITS);
  localparam int DIV_S = ACC_W + 4;
  localparam int MQ_W  = ACC_W + DIV_S;

  // Reciprocal of ten, rounded up; exact quotient for any accumulator value.
  localparam logic [DIV_S-1:0] DIV_M = DIV_S'((64'd1 << DIV_S) / 64'd10 + 64'd1);
  localparam logic [ACC_W-1:0] ACC_MAX = ACC_W'(90 * MAX_DIGITS - 1);

  logic [EW-1:0] pos_e, col_e;
  logic [3:0]    dig_sat;
  logic          load_a, load_b, rd_sum, rd_prod;
  logic          col_in_ab, col_in_sum;

  logic          a_we, b_we, s_we, p_we;
  logic [AW-1:0] a_wa, b_wa;
  logic [3:0]    a_wd, b_wd, s_wd, p_wd;
  logic [SW-1:0] s_wa, s_ra;
  logic [PW-1:0] p_wa, p_ra;
  logic [3:0]    a_q, b_q, s_q, p_q;

  logic             rd_d_r, a_ok_d_r, b_ok_d_r, mul_d_r;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [7:0]       sum_top_r, sum_top_nxt;
  logic [7:0]       prod_top_r, prod_top_nxt;
  logic             out_valid_r;
  logic             rsel_prod_r, rin_range_r;

  logic [3:0]       da, db;
  logic [7:0]       term;
  logic [MQ_W-1:0]  mq;
  logic [ACC_W-1:0] quot, rem_w;
  logic [7:0]       top_sat;

  assign pos_e   = EW'(in_item.position);
  assign col_e   = EW'(col);
  assign dig_sat = (in_item.digit_in > ddam_pkg::DIGIT_MAX) ? ddam_pkg::DIGIT_MAX
                                                             : in_item.digit_in;

  assign load_a  = accept && (in_item.req_type == ddam_pkg::REQ_LOAD_A) &&
                   (pos_e < EW'(MAX_DIGITS));
  assign load_b  = accept && (in_item.req_type == ddam_pkg::REQ_LOAD_B) &&
                   (pos_e < EW'(MAX_DIGITS));
  assign rd_sum  = accept && (in_item.req_type == ddam_pkg::REQ_READ_S);
  assign rd_prod = accept && (in_item.req_type == ddam_pkg::REQ_READ_P);

  assign col_in_ab  = (col_e < EW'(MAX_DIGITS));
  assign col_in_sum = (col_e < EW'(SDEP));

  // Operand stores: written by loads and by the clearing pass.
  assign a_we = load_a || (cmd.clr && col_in_ab);
  assign b_we = load_b || (cmd.clr && col_in_ab);
  assign a_wa = cmd.clr ? col[AW-1:0] : pos_e[AW-1:0];
  assign b_wa = a_wa;
  assign a_wd = cmd.clr ? 4'd0 : dig_sat;
  assign b_wd = a_wd;

  // Result stores: written by the clearing pass and by each column split.
  assign s_we = (cmd.clr && col_in_sum) || (cmd.norm && !cmd.norm_prod);
  assign p_we = cmd.clr || (cmd.norm && cmd.norm_prod);
  assign s_wa = col[SW-1:0];
  assign p_wa = col;
  assign s_wd = cmd.clr ? 4'd0 : rem_w[3:0];
  assign p_wd = s_wd;
  assign s_ra = pos_e[SW-1:0];
  assign p_ra = pos_e[PW-1:0];

  ddam_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS)) u_ram_a (
    .clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd),
    .re(cmd.rd), .raddr(a_addr), .rdata(a_q)
  );

  ddam_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS)) u_ram_b (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd),
    .re(cmd.rd), .raddr(b_addr), .rdata(b_q)
  );

  ddam_ram #(.WIDTH(4), .DEPTH(SDEP)) u_ram_sum (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd),
    .re(rd_sum && (pos_e < EW'(SDEP))), .raddr(s_ra), .rdata(s_q)
  );

  ddam_ram #(.WIDTH(4), .DEPTH(PDEP)) u_ram_prod (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd),
    .re(rd_prod && (pos_e < EW'(PDEP))), .raddr(p_ra), .rdata(p_q)
  );

  // Operand digits arrive in the cycle after the read; digits outside a
  // length count as zero.
  assign da   = a_ok_d_r ? a_q : 4'd0;
  assign db   = b_ok_d_r ? b_q : 4'd0;
  assign term = mul_d_r ? (8'(da) * 8'(db)) : (8'(da) + 8'(db));

  assign mq      = MQ_W'(acc_r) * MQ_W'(DIV_M);
  assign quot    = mq[MQ_W-1:DIV_S];
  assign rem_w   = acc_r - ((quot << 3) + (quot << 1));
  assign top_sat = (col_e > EW'(ddam_pkg::TOP_SAT)) ? ddam_pkg::TOP_SAT : col_e[7:0];

  always_comb begin
    acc_nxt      = acc_r;
    sum_top_nxt  = sum_top_r;
    prod_top_nxt = prod_top_r;
    if (cmd.acc_clr) begin
      acc_nxt      = '0;
      sum_top_nxt  = '0;
      prod_top_nxt = '0;
    end else if (rd_d_r) begin
      acc_nxt = acc_r + ACC_W'(term);
    end else if (cmd.norm) begin
      acc_nxt = quot;
      if (rem_w[3:0] != 4'd0) begin
        if (cmd.norm_prod) begin
          prod_top_nxt = top_sat;
        end else begin
          sum_top_nxt = top_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_d_r      <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      sum_top_r   <= '0;
      prod_top_r  <= '0;
    end else begin
      rd_d_r      <= cmd.rd;
      out_valid_r <= rd_sum || rd_prod;
      acc_r       <= acc_nxt;
      sum_top_r   <= sum_top_nxt;
      prod_top_r  <= prod_top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_ok_d_r <= cmd.a_ok;
    b_ok_d_r <= cmd.b_ok;
    mul_d_r  <= cmd.mul;
    if (rd_sum || rd_prod) begin
      rsel_prod_r <= rd_prod;
      rin_range_r <= rd_prod ? (pos_e < EW'(PDEP)) : (pos_e < EW'(SDEP));
    end
  end

  assign out_valid          = out_valid_r;
  assign out_item.digit_out = !rin_range_r ? 4'd0 : (rsel_prod_r ? p_q : s_q);
  assign out_item.top_index = rsel_prod_r ? prod_top_r : sum_top_r;

  a_result_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(rd_sum || rd_prod))
    else $error("result strobe without a read transfer");

  a_acc_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r <= ACC_MAX)
    else $error("column accumulator beyond its bound");

  a_result_digit_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.norm |-> (rem_w < ACC_W'(10)))
    else $error("split by ten left a remainder above nine");

endmodule

[rtl/core/decimal_digit_add_multiply.sv]
// Top level of the decimal add and multiply engine: APB register file for
// the operand lengths, sequencer and datapath. Depends on ddam_pkg,
// ddam_ctrl, ddam_dpath and ddam_ram.
//
//  channel  | ports                                   | transfer
//  ---------+-----------------------------------------+--------------------------------
//  request  | start, busy, in_item                    | start high while busy low
//  result   | out_valid, out_item                     | one cycle, cannot be held off
//  config   | psel penable pwrite paddr pwdata prdata | psel, penable, pwrite, pready
//
// Loads and reads do not raise busy; a read result shows in the cycle after
// its transfer, while the next request is already taken.
// A compute keeps busy high while the sum runs over MAX_DIGITS+1 columns and
// the product over 2*MAX_DIGITS columns, one term at a time:
// every product term goes through one operand read port and one accumulator.
// After reset, busy stays high while a clearing pass over 2*MAX_DIGITS
// columns zeroes all digit stores; register writes are taken meanwhile.
module decimal_digit_add_multiply #(
  parameter int MAX_DIGITS = ddam_pkg::MAX_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ddam_pkg::ddam_in_t  in_item,
  output logic                out_valid,
  output ddam_pkg::ddam_out_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int PW = $clog2(2*MAX_DIGITS);

  logic [7:0] len_a_r, len_a_nxt;
  logic [7:0] len_b_r, len_b_nxt;
  logic       cfg_wr;
  logic       accept;

  ddam_pkg::ddam_cmd_t cmd;
  logic [PW-1:0]       col;
  logic [AW-1:0]       a_addr, b_addr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign accept = start && !busy;

  always_comb begin
    len_a_nxt = len_a_r;
    len_b_nxt = len_b_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        ddam_pkg::REG_LEN_A: len_a_nxt = pwdata[7:0];
        ddam_pkg::REG_LEN_B: len_b_nxt = pwdata[7:0];
        default: begin
          len_a_nxt = len_a_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_a_r <= ddam_pkg::LEN_RESET;
      len_b_r <= ddam_pkg::LEN_RESET;
    end else begin
      len_a_r <= len_a_nxt;
      len_b_r <= len_b_nxt;
    end
  end

  assign prdata = (paddr[2] == ddam_pkg::REG_LEN_B) ? {24'd0, len_b_r} : {24'd0, len_a_r};

  ddam_ctrl #(.MAX_DIGITS(MAX_DIGITS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_item.req_type),
    .len_a    (len_a_r),
    .len_b    (len_b_r),
    .busy     (busy),
    .cmd      (cmd),
    .col      (col),
    .a_addr   (a_addr),
    .b_addr   (b_addr)
  );

  ddam_dpath #(.MAX_DIGITS(MAX_DIGITS)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_item),
    .cmd       (cmd),
    .col       (col),
    .a_addr    (a_addr),
    .b_addr    (b_addr),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
